FILE: rtl/hbs_pkg.sv
`default_nettype none
package hbs_pkg;

   // Item kinds carried on req_command.
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_FREQUENCY     = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;
   localparam logic [1:0] REG_BILINEAR_MODE = 2'd3;

   localparam logic [15:0] FREQUENCY_RESET = 16'd8192;
   localparam logic [8:0]  SIZE_RESET      = 9'd256;

   // Queue depths between front and back, and in front of the result port.
   localparam int MQ_DEPTH = 4;
   localparam int OQ_DEPTH = 8;

   // floor(2^23 / 255): reciprocal used to divide the blended sum by 510.
   localparam logic [15:0] RECIP_255    = 16'd32896;
   localparam logic [15:0] LEVEL_OFFSET = 16'd16384;

   typedef struct packed {
      logic is_sample;
      logic write_ok;
   } item_kind_type;

endpackage
`default_nettype wire

FILE: rtl/hbs_queue.sv
`default_nettype none
module hbs_queue
   import hbs_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [WIDTH-1:0]             din,
   input  wire logic                         pop,
   output logic      [WIDTH-1:0]             dout,
   output logic                              empty,
   output logic      [$clog2(DEPTH+1)-1:0]   count
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[tail_ff] <= din;
      end
   end

   assign dout  = mem_ff[head_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

`ifndef ASSERT_OFF
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0) else $error("queue popped while empty");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> count_ff != CW'(DEPTH)) else $error("queue pushed while full");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a push");
`endif
endmodule
`default_nettype wire

FILE: rtl/hbs_front.sv
`default_nettype none
module hbs_front
   import hbs_pkg::*;
#(
   parameter int MAX_DIM = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              accept,
   input  wire logic                              req_command,
   input  wire logic        [7:0]                 req_pixel_column,
   input  wire logic        [7:0]                 req_pixel_row,
   input  wire logic        [7:0]                 req_pixel_level,
   input  wire logic signed [31:0]                req_x_pos,
   input  wire logic signed [31:0]                req_z_pos,
   input  wire logic        [15:0]                frequency,
   input  wire logic        [$clog2(MAX_DIM+1)-1:0] eff_width,
   input  wire logic        [$clog2(MAX_DIM+1)-1:0] eff_height,
   input  wire logic                              bilinear_mode,
   output logic                                   busy,
   output logic                                   out_valid,
   output item_kind_type                          out_kind,
   output logic [$clog2(MAX_DIM)-1:0]             out_sx,
   output logic [$clog2(MAX_DIM)-1:0]             out_sx1,
   output logic [$clog2(MAX_DIM)-1:0]             out_sy,
   output logic [$clog2(MAX_DIM)-1:0]             out_sy1,
   output logic [7:0]                             out_fx,
   output logic [7:0]                             out_fz,
   output logic [7:0]                             out_level
);
   localparam int IW = $clog2(MAX_DIM);
   localparam int SW = $clog2(MAX_DIM+1);
   localparam int UW = 50;

   logic               valid_ff;
   logic               cmd_ff;
   logic [7:0]         col_ff, row_ff, level_ff;
   logic signed [47:0] prod_x_ff, prod_z_ff;
   logic signed [47:0] prod_x_in, prod_z_in;

   logic [UW-1:0] ux, uz;
   logic [IW-1:0] sx, sy;

   assign prod_x_in = 48'(req_x_pos) * 48'($signed({1'b0, frequency}));
   assign prod_z_in = 48'(req_z_pos) * 48'($signed({1'b0, frequency}));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      if (accept) begin
         cmd_ff    <= req_command;
         col_ff    <= req_pixel_column;
         row_ff    <= req_pixel_row;
         level_ff  <= req_pixel_level;
         prod_x_ff <= prod_x_in;
         prod_z_ff <= prod_z_in;
      end
   end

   // Shift to pixel units with zero at the centre, then clamp to the image.
   function automatic logic [UW-1:0] to_pixel(input logic signed [47:0] prod,
                                              input logic [SW-1:0] size);
      logic signed [UW-1:0] u;
      logic signed [UW-1:0] hi;
      logic        [SW-1:0] size_m1;
      size_m1 = size - 1'b1;
      u  = {{(UW-48){prod[47]}}, prod} + $signed({{(UW-SW-23){1'b0}}, size, 23'b0});
      hi = $signed({{(UW-SW-24){1'b0}}, size_m1, 24'b0});
      if (u < 0) begin
         return '0;
      end else if (u > hi) begin
         return hi;
      end
      return u;
   endfunction

   assign ux = to_pixel(prod_x_ff, eff_width);
   assign uz = to_pixel(prod_z_ff, eff_height);
   assign sx = IW'(ux >> 24);
   assign sy = IW'(uz >> 24);

   always_comb begin
      out_kind.is_sample = (cmd_ff == CMD_SAMPLE);
      out_kind.write_ok  = (int'(col_ff) < MAX_DIM) && (int'(row_ff) < MAX_DIM);
      out_level = level_ff;
      if (cmd_ff == CMD_SAMPLE) begin
         out_sx  = sx;
         out_sy  = sy;
         out_sx1 = (sx == IW'(eff_width - 1'b1)) ? sx : sx + 1'b1;
         out_sy1 = (sy == IW'(eff_height - 1'b1)) ? sy : sy + 1'b1;
         out_fx  = bilinear_mode ? ux[23:16] : 8'd0;
         out_fz  = bilinear_mode ? uz[23:16] : 8'd0;
      end else begin
         out_sx  = IW'(col_ff);
         out_sy  = IW'(row_ff);
         out_sx1 = IW'(col_ff);
         out_sy1 = IW'(row_ff);
         out_fx  = 8'd0;
         out_fz  = 8'd0;
      end
   end

   assign out_valid = valid_ff;
   assign busy      = valid_ff;
endmodule
`default_nettype wire

FILE: rtl/hbs_back.sv
`default_nettype none
module hbs_back
   import hbs_pkg::*;
#(
   parameter int MAX_DIM = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_avail,
   input  wire item_kind_type                 in_kind,
   input  wire logic [$clog2(MAX_DIM)-1:0]    in_sx,
   input  wire logic [$clog2(MAX_DIM)-1:0]    in_sx1,
   input  wire logic [$clog2(MAX_DIM)-1:0]    in_sy,
   input  wire logic [$clog2(MAX_DIM)-1:0]    in_sy1,
   input  wire logic [7:0]                    in_fx,
   input  wire logic [7:0]                    in_fz,
   input  wire logic [7:0]                    in_level,
   input  wire logic [$clog2(OQ_DEPTH+1)-1:0] oq_count,
   output logic                               in_take,
   output logic                               out_push,
   output logic [15:0]                        out_height
);
   localparam int IW     = $clog2(MAX_DIM);
   localparam int HALF   = (MAX_DIM + 1) / 2;
   localparam int BDEPTH = HALF * HALF;
   localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
   localparam int OCW    = $clog2(OQ_DEPTH+1);

   // Four banks split by row and column parity, so a 2x2 neighborhood of four
   // distinct pixels hits each bank once.
   logic [7:0]     bank_mem [4][BDEPTH];
   logic [BAW-1:0] rd_addr [4];
   logic [BAW-1:0] wr_addr;
   logic [1:0]     wr_bank;
   logic           wr_en;

   logic [IW-1:0]  col_of [2];
   logic [IW-1:0]  row_of [2];

   logic [8:0]  wx0, wz0;
   logic [16:0] w_in [4];

   logic        b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff;
   logic [7:0]  rd_ff [4];
   logic [16:0] w_ff [4];
   logic        px0_ff, px1_ff, py0_ff, py1_ff;
   logic [24:0] p_ff [4];
   logic [24:0] p_in [4];
   logic [7:0]  l_sel [4];
   logic [24:0] n_in;
   logic [23:0] m3_ff, m4_ff;
   logic [39:0] recip_prod;
   logic [16:0] qe_ff;
   logic [24:0] rem;
   logic [16:0] q;
   logic [2:0]  inflight;

   function automatic logic [BAW-1:0] bank_addr(input logic [IW-1:0] col,
                                                input logic [IW-1:0] row);
      return BAW'((int'(row) / 2) * HALF + int'(col) / 2);
   endfunction

   assign inflight = 3'(b1_valid_ff) + 3'(b2_valid_ff) + 3'(b3_valid_ff)
                     + 3'(b4_valid_ff);
   assign in_take  = in_avail && ((OCW+1)'(oq_count) + (OCW+1)'(inflight)
                                  < (OCW+1)'(OQ_DEPTH));

   always_comb begin
      col_of[0] = in_sx[0] ? in_sx1 : in_sx;
      col_of[1] = in_sx[0] ? in_sx : in_sx1;
      row_of[0] = in_sy[0] ? in_sy1 : in_sy;
      row_of[1] = in_sy[0] ? in_sy : in_sy1;
      for (int b = 0; b < 4; b++) begin
         rd_addr[b] = bank_addr(col_of[b % 2], row_of[b / 2]);
      end
      wr_en   = in_take && !in_kind.is_sample && in_kind.write_ok;
      wr_bank = {in_sy[0], in_sx[0]};
      wr_addr = bank_addr(in_sx, in_sy);
      wx0     = 9'd256 - 9'(in_fx);
      wz0     = 9'd256 - 9'(in_fz);
      w_in[0] = 17'(wx0) * 17'(wz0);
      w_in[1] = 17'(in_fx) * 17'(wz0);
      w_in[2] = 17'(wx0) * 17'(in_fz);
      w_in[3] = 17'(in_fx) * 17'(in_fz);
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < 4; b++) begin
         if (wr_en && wr_bank == 2'(b)) begin
            bank_mem[b][wr_addr] <= in_level;
         end
         rd_ff[b] <= bank_mem[b][rd_addr[b]];
         w_ff[b]  <= w_in[b];
      end
      px0_ff <= in_sx[0];
      px1_ff <= in_sx1[0];
      py0_ff <= in_sy[0];
      py1_ff <= in_sy1[0];
   end

   always_comb begin
      l_sel[0] = rd_ff[{py0_ff, px0_ff}];
      l_sel[1] = rd_ff[{py0_ff, px1_ff}];
      l_sel[2] = rd_ff[{py1_ff, px0_ff}];
      l_sel[3] = rd_ff[{py1_ff, px1_ff}];
      for (int b = 0; b < 4; b++) begin
         p_in[b] = 25'(l_sel[b]) * 25'(w_ff[b]);
      end
      n_in = p_ff[0] + p_ff[1] + p_ff[2] + p_ff[3] + 25'd255;
   end

   // Division by 510: halve, then divide by 255 with a reciprocal that
   // undershoots by at most one, fixed by a single compare.
   assign recip_prod = 40'(m3_ff) * 40'(RECIP_255);
   assign rem        = {1'b0, m4_ff} - 25'(qe_ff) * 25'd255;
   assign q          = (rem >= 25'd255) ? qe_ff + 1'b1 : qe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= in_take && in_kind.is_sample;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         b4_valid_ff <= b3_valid_ff;
      end
      for (int b = 0; b < 4; b++) begin
         p_ff[b] <= p_in[b];
      end
      m3_ff <= n_in[24:1];
      m4_ff <= m3_ff;
      qe_ff <= recip_prod[39:23];
   end

   assign out_push   = b4_valid_ff;
   assign out_height = q[15:0] - LEVEL_OFFSET;
endmodule
`default_nettype wire

FILE: rtl/heightmap_bilinear_sampler.sv
`default_nettype none
// Heightmap sampler with switchable bilinear blending and clamp to edge.
// Input channel: drive push with req_command and its fields; an item is
// taken on a clock edge where push is high and full is low. A load item
// (command 0) writes one pixel and gives no result. A sample item
// (command 1) gives one height on rsp_height, signed Q1.14.
// Result channel: rsp_height holds the oldest result while empty is low;
// it is taken on an edge where pop is high and empty is low.
// Throughput: one item per cycle while full is low; the heightmap sits in
// four parity banks so all four neighbors are read in the same cycle.
// A stalled receiver fills the result queue (eight entries); the back end
// then stops drawing from the four-entry queue behind the coordinate
// front end, and full rises once that fills. Nothing is dropped.
// Reset empties both queues and loads the register defaults; the heightmap
// contents are not cleared. Write the csr_ registers only while idle.
module heightmap_bilinear_sampler
   import hbs_pkg::*;
#(
   parameter int MAX_DIM = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic               req_command,
   input  wire logic [7:0]         req_pixel_column,
   input  wire logic [7:0]         req_pixel_row,
   input  wire logic [7:0]         req_pixel_level,
   input  wire logic signed [31:0] req_x_pos,
   input  wire logic signed [31:0] req_z_pos,
   output logic                    empty,
   input  wire logic               pop,
   output logic signed [15:0]      rsp_height,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data
);
   localparam int IW  = $clog2(MAX_DIM);
   localparam int SW  = $clog2(MAX_DIM+1);
   localparam int QW  = 2 + 4*IW + 24;
   localparam int MCW = $clog2(MQ_DEPTH+1);
   localparam int OCW = $clog2(OQ_DEPTH+1);

   logic [15:0] frequency_ff;
   logic [8:0]  width_ff, height_ff;
   logic        bilinear_ff;
   logic [SW-1:0] eff_width, eff_height;

   logic          accept, front_busy, front_valid;
   item_kind_type front_kind, back_kind;
   logic [IW-1:0] f_sx, f_sx1, f_sy, f_sy1, b_sx, b_sx1, b_sy, b_sy1;
   logic [7:0]    f_fx, f_fz, f_level, b_fx, b_fz, b_level;
   logic [QW-1:0] mq_din, mq_dout;
   logic          mq_empty, mq_pop;
   logic [MCW-1:0] mq_count;
   logic          oq_push, oq_pop;
   logic [15:0]   oq_din, oq_dout;
   logic [OCW-1:0] oq_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         frequency_ff <= FREQUENCY_RESET;
         width_ff     <= SIZE_RESET;
         height_ff    <= SIZE_RESET;
         bilinear_ff  <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_FREQUENCY:     frequency_ff <= csr_data;
            REG_IMAGE_WIDTH:   width_ff     <= csr_data[8:0];
            REG_IMAGE_HEIGHT:  height_ff    <= csr_data[8:0];
            REG_BILINEAR_MODE: bilinear_ff  <= csr_data[0];
            default:           ;
         endcase
      end
   end

   function automatic logic [SW-1:0] eff_size(input logic [8:0] s);
      if (s == 9'd0) begin
         return SW'(1);
      end else if (int'(s) > MAX_DIM) begin
         return SW'(MAX_DIM);
      end
      return SW'(s);
   endfunction

   assign eff_width  = eff_size(width_ff);
   assign eff_height = eff_size(height_ff);

   // The front end registers one item; count it against the queue space.
   assign full   = ((MCW+1)'(mq_count) + (MCW+1)'(front_busy)) >= (MCW+1)'(MQ_DEPTH);
   assign accept = push && !full;

   hbs_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_command      (req_command),
      .req_pixel_column (req_pixel_column),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_level  (req_pixel_level),
      .req_x_pos        (req_x_pos),
      .req_z_pos        (req_z_pos),
      .frequency        (frequency_ff),
      .eff_width        (eff_width),
      .eff_height       (eff_height),
      .bilinear_mode    (bilinear_ff),
      .busy             (front_busy),
      .out_valid        (front_valid),
      .out_kind         (front_kind),
      .out_sx           (f_sx),
      .out_sx1          (f_sx1),
      .out_sy           (f_sy),
      .out_sy1          (f_sy1),
      .out_fx           (f_fx),
      .out_fz           (f_fz),
      .out_level        (f_level)
   );

   assign mq_din = {front_kind, f_sx, f_sx1, f_sy, f_sy1, f_fx, f_fz, f_level};
   assign {back_kind, b_sx, b_sx1, b_sy, b_sy1, b_fx, b_fz, b_level} = mq_dout;

   hbs_queue #(.WIDTH(QW), .DEPTH(MQ_DEPTH)) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_valid),
      .din   (mq_din),
      .pop   (mq_pop),
      .dout  (mq_dout),
      .empty (mq_empty),
      .count (mq_count)
   );

   hbs_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_avail   (!mq_empty),
      .in_kind    (back_kind),
      .in_sx      (b_sx),
      .in_sx1     (b_sx1),
      .in_sy      (b_sy),
      .in_sy1     (b_sy1),
      .in_fx      (b_fx),
      .in_fz      (b_fz),
      .in_level   (b_level),
      .oq_count   (oq_count),
      .in_take    (mq_pop),
      .out_push   (oq_push),
      .out_height (oq_din)
   );

   assign oq_pop = pop && !empty;

   hbs_queue #(.WIDTH(16), .DEPTH(OQ_DEPTH)) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (oq_push),
      .din   (oq_din),
      .pop   (oq_pop),
      .dout  (oq_dout),
      .empty (empty),
      .count (oq_count)
   );

   assign rsp_height = $signed(oq_dout);

`ifndef ASSERT_OFF
   a_mid_room: assert property (@(posedge clock) disable iff (reset)
      (front_valid && !mq_pop) |-> mq_count != MCW'(MQ_DEPTH))
      else $error("front end pushed into a full middle queue");
   a_out_room: assert property (@(posedge clock) disable iff (reset)
      oq_push |-> oq_count != OCW'(OQ_DEPTH))
      else $error("result pushed into a full result queue");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queues not empty after reset");
`endif
endmodule
`default_nettype wire
